>>> rtl/hrwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrwp_pkg
// Shared types and constants of the homopolymer run weight pixel unit.
// ----------------------------------------------------------------------------
package hrwp_pkg;

  localparam int unsigned MAX_WEIGHT_LIMIT = 63;
  localparam int unsigned BASE_W           = 8;
  localparam int unsigned PIXEL_W          = 8;
  localparam int unsigned COUNT_W          = $clog2(MAX_WEIGHT_LIMIT + 1);
  localparam int unsigned PROD_W           = COUNT_W + PIXEL_W;
  localparam int unsigned STEP_W           = $clog2(PIXEL_W);

  localparam logic [PIXEL_W-1:0] PIXEL_FULL       = PIXEL_W'(254);
  localparam logic [COUNT_W-1:0] MAX_WEIGHT_RESET = COUNT_W'(6);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // One burst of equal pixels for the back end.
  typedef struct packed {
    logic               full;     // pixel value is PIXEL_FULL, no division
    logic [COUNT_W-1:0] weight;   // clamped run weight
    logic [COUNT_W-1:0] sat_len;  // saturation length
    logic [COUNT_W-1:0] count;    // number of pixels, at least one
    logic               last;     // final burst of the sequence
  } cmd_t;

  function automatic cmd_t full_cmd(logic [COUNT_W-1:0] count);
    cmd_t c;
    c.full    = 1'b1;
    c.weight  = '0;
    c.sat_len = '0;
    c.count   = count;
    c.last    = 1'b0;
    return c;
  endfunction

  function automatic cmd_t flush_cmd(logic [COUNT_W-1:0] count, logic [COUNT_W-1:0] m);
    cmd_t c;
    c.full    = 1'b0;
    c.weight  = (count > m) ? m : count;
    c.sat_len = m;
    c.count   = count;
    c.last    = 1'b0;
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hrwp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrwp_front
// Accepts bases, tracks the open run and turns run events into pixel bursts.
// ----------------------------------------------------------------------------
module hrwp_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [hrwp_pkg::BASE_W-1:0]  base_i,
  input  wire logic                         last_i,
  input  wire logic [hrwp_pkg::COUNT_W-1:0] sat_len_i,
  output logic                              cmd_push_o,
  output hrwp_pkg::cmd_t                    cmd_o,
  input  wire logic                         cmd_full_i
);

  logic [hrwp_pkg::BASE_W-1:0]  prev_q, prev_d;
  logic [hrwp_pkg::COUNT_W-1:0] pend_q, pend_d;
  logic                         have_q, have_d;
  logic                         sat_q, sat_d;
  logic                         hold_vld_q;
  hrwp_pkg::cmd_t               hold_q;

  logic                         accept;
  logic                         same;
  logic [hrwp_pkg::COUNT_W-1:0] pend_inc;
  logic [hrwp_pkg::COUNT_W-1:0] run_pend;
  logic                         run_sat;
  logic                         a_vld, n_vld, l_vld;
  hrwp_pkg::cmd_t               a_cmd, n_cmd, l_cmd;
  logic                         c0_vld, c1_vld;
  hrwp_pkg::cmd_t               c0, c1;

  assign full   = hold_vld_q || cmd_full_i;
  assign accept = push && !full;

  always_comb begin
    prev_d   = prev_q;
    have_d   = have_q;
    run_pend = pend_q;
    run_sat  = sat_q;
    a_vld    = 1'b0;
    n_vld    = 1'b0;
    l_vld    = 1'b0;
    a_cmd    = hrwp_pkg::full_cmd(hrwp_pkg::COUNT_W'(1));
    n_cmd    = hrwp_pkg::full_cmd(hrwp_pkg::COUNT_W'(1));
    l_cmd    = hrwp_pkg::full_cmd(hrwp_pkg::COUNT_W'(1));
    same     = have_q && (base_i == prev_q);
    pend_inc = pend_q + hrwp_pkg::COUNT_W'(1);

    if (same) begin
      if (sat_q) begin
        a_vld = 1'b1;
      end else if (({1'b0, pend_q} + (hrwp_pkg::COUNT_W + 1)'(1)) >= {1'b0, sat_len_i}) begin
        a_vld    = 1'b1;
        a_cmd    = hrwp_pkg::full_cmd(pend_inc);
        run_pend = '0;
        run_sat  = 1'b1;
      end else begin
        run_pend = pend_inc;
      end
    end else begin
      if (have_q && !sat_q && (pend_q != '0)) begin
        a_vld = 1'b1;
        a_cmd = hrwp_pkg::flush_cmd(pend_q, sat_len_i);
      end
      prev_d = base_i;
      have_d = 1'b1;
      if (sat_len_i <= hrwp_pkg::COUNT_W'(1)) begin
        n_vld    = 1'b1;
        run_pend = '0;
        run_sat  = 1'b1;
      end else begin
        run_pend = hrwp_pkg::COUNT_W'(1);
        run_sat  = 1'b0;
      end
    end

    pend_d = run_pend;
    sat_d  = run_sat;
    if (last_i) begin
      if (!run_sat && (run_pend != '0)) begin
        l_vld = 1'b1;
        l_cmd = hrwp_pkg::flush_cmd(run_pend, sat_len_i);
      end
      prev_d = '0;
      pend_d = '0;
      have_d = 1'b0;
      sat_d  = 1'b0;
    end

    if (a_vld) begin
      c0_vld = 1'b1;
      c0     = a_cmd;
      c1_vld = n_vld || l_vld;
      c1     = n_vld ? n_cmd : l_cmd;
    end else begin
      c0_vld = n_vld || l_vld;
      c0     = n_vld ? n_cmd : l_cmd;
      c1_vld = 1'b0;
      c1     = l_cmd;
    end
    c0.last = last_i && !c1_vld;
    c1.last = last_i;
  end

  always_comb begin
    if (hold_vld_q) begin
      cmd_push_o = !cmd_full_i;
      cmd_o      = hold_q;
    end else begin
      cmd_push_o = accept && c0_vld;
      cmd_o      = c0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      pend_q     <= '0;
      have_q     <= 1'b0;
      sat_q      <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        prev_q     <= prev_d;
        pend_q     <= pend_d;
        have_q     <= have_d;
        sat_q      <= sat_d;
        hold_vld_q <= c1_vld;
      end else if (hold_vld_q && !cmd_full_i) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= c1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!have_q && !sat_q) || have_q)
    else $error("saturated run without an open run");

endmodule
`default_nettype wire

>>> rtl/hrwp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrwp_fifo
// Short command queue between the front end and the pixel back end.
// ----------------------------------------------------------------------------
module hrwp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hrwp_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output hrwp_pkg::cmd_t      data_o,
  output logic                empty_o
);

  hrwp_pkg::cmd_t                mem_q [hrwp_pkg::FIFO_DEPTH];
  logic [hrwp_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [hrwp_pkg::FIFO_PTR_W:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (hrwp_pkg::FIFO_PTR_W + 1)'(hrwp_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + hrwp_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + hrwp_pkg::FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (hrwp_pkg::FIFO_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (hrwp_pkg::FIFO_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (hrwp_pkg::FIFO_PTR_W + 1)'(hrwp_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

endmodule
`default_nettype wire

>>> rtl/hrwp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrwp_back
// Scales non-full burst weights by a shift-subtract divider and emits pixels.
// ----------------------------------------------------------------------------
module hrwp_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hrwp_pkg::cmd_t               cmd_i,
  input  wire logic                         cmd_empty_i,
  output logic                              cmd_pop_o,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [hrwp_pkg::PIXEL_W-1:0]      pixel_o,
  output logic                              last_pixel_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [hrwp_pkg::COUNT_W-1:0] rem_q, rem_d;
  logic [hrwp_pkg::PIXEL_W-1:0] dvd_q, dvd_d;
  logic [hrwp_pkg::PIXEL_W-1:0] quo_q, quo_d;
  logic [hrwp_pkg::COUNT_W-1:0] m_q, m_d;
  logic [hrwp_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic [hrwp_pkg::STEP_W-1:0]  step_q, step_d;
  logic                         last_q, last_d;

  logic [hrwp_pkg::PROD_W-1:0]  prod;
  logic [hrwp_pkg::COUNT_W:0]   trial;
  logic                         ge;

  assign prod  = hrwp_pkg::PROD_W'(cmd_i.weight) * hrwp_pkg::PROD_W'(hrwp_pkg::PIXEL_FULL);
  assign trial = {rem_q, dvd_q[hrwp_pkg::PIXEL_W-1]};
  assign ge    = (trial >= {1'b0, m_q});

  assign cmd_pop_o    = (state_q == ST_IDLE) && !cmd_empty_i;
  assign empty        = (state_q != ST_EMIT);
  assign pixel_o      = quo_q;
  assign last_pixel_o = last_q && (cnt_q == hrwp_pkg::COUNT_W'(1));

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cnt_d  = cmd_i.count;
          last_d = cmd_i.last;
          m_d    = cmd_i.sat_len;
          rem_d  = prod[hrwp_pkg::PROD_W-1:hrwp_pkg::PIXEL_W];
          dvd_d  = prod[hrwp_pkg::PIXEL_W-1:0];
          step_d = hrwp_pkg::STEP_W'(hrwp_pkg::PIXEL_W - 1);
          if (cmd_i.full) begin
            quo_d   = hrwp_pkg::PIXEL_FULL;
            state_d = ST_EMIT;
          end else begin
            quo_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? hrwp_pkg::COUNT_W'(trial - {1'b0, m_q}) : trial[hrwp_pkg::COUNT_W-1:0];
        dvd_d  = {dvd_q[hrwp_pkg::PIXEL_W-2:0], 1'b0};
        quo_d  = {quo_q[hrwp_pkg::PIXEL_W-2:0], ge};
        step_d = step_q - hrwp_pkg::STEP_W'(1);
        if (step_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pop) begin
          cnt_d = cnt_q - hrwp_pkg::COUNT_W'(1);
          if (cnt_q == hrwp_pkg::COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    m_q   <= m_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("emitting a burst with no pixels left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (quo_q <= hrwp_pkg::PIXEL_FULL))
    else $error("pixel above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (m_q != '0))
    else $error("division by zero saturation length");

endmodule
`default_nettype wire

>>> rtl/homopolymer_run_weight_pixels_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homopolymer_run_weight_pixels_unit
// One pixel per base: run length clamped to max_weight, scaled to 0..254.
//
//   channel  direction  handshake                  payload
//   input    in         push / full                base_i, last_i
//   result   out        empty / pop                pixel_o, last_pixel_o
//   config   in         cfg_valid_i / cfg_ready_o  cfg_data_i (max_weight)
//
// A base that yields two bursts holds full high while the second waits.
// Each burst leaves the queue, is divided by the shift-subtract divider
// unless its pixel is 254; its pixels go out before the next. Input stalls
// while the four-entry queue is full or a burst is held. Reset clears all
// control state at once; no clearing pass. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module homopolymer_run_weight_pixels_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [hrwp_pkg::BASE_W-1:0]  base_i,
  input  wire logic                         last_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [hrwp_pkg::PIXEL_W-1:0]      pixel_o,
  output logic                              last_pixel_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [hrwp_pkg::COUNT_W-1:0] cfg_data_i
);

  logic [hrwp_pkg::COUNT_W-1:0] max_weight_q;
  logic [hrwp_pkg::COUNT_W-1:0] sat_len;
  logic                         q_push, q_full, q_pop, q_empty;
  hrwp_pkg::cmd_t               q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign sat_len     = (max_weight_q == '0) ? hrwp_pkg::COUNT_W'(1) : max_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_weight_q <= hrwp_pkg::MAX_WEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_weight_q <= cfg_data_i;
    end
  end

  hrwp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .base_i     (base_i),
    .last_i     (last_i),
    .sat_len_i  (sat_len),
    .cmd_push_o (q_push),
    .cmd_o      (q_wdata),
    .cmd_full_i (q_full)
  );

  hrwp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  hrwp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_rdata),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .empty        (empty),
    .pop          (pop),
    .pixel_o      (pixel_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the homopolymer run weight pixel unit. A driver
// feeds bases and max_weight writes from a pending queue, a run-length
// predictor builds the expected pixel stream, and a monitor compares every
// popped pixel with it. Both sides idle in short random bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QUIET_CYCLES = 32;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TAIL_TXNS    = 60;
  localparam int unsigned PHASE_BASES  = 34;
  localparam int unsigned LONG_RUN     = 66;

  typedef enum logic [1:0] {
    TXN_BASE,
    TXN_CFG,
    TXN_DRAIN
  } txn_kind_e;

  typedef struct {
    txn_kind_e                    kind;
    logic [hrwp_pkg::BASE_W-1:0]  base;
    logic                         last;
    logic [hrwp_pkg::COUNT_W-1:0] data;
  } txn_t;

  typedef struct {
    logic [hrwp_pkg::PIXEL_W-1:0] pixel;
    logic                         last;
  } pixel_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          push         = 1'b0;
  logic                          full;
  logic [hrwp_pkg::BASE_W-1:0]   base_i       = '0;
  logic                          last_i       = 1'b0;
  logic                          empty;
  logic                          pop          = 1'b0;
  logic [hrwp_pkg::PIXEL_W-1:0]  pixel_o;
  logic                          last_pixel_o;
  logic                          cfg_valid_i  = 1'b0;
  logic                          cfg_ready_o;
  logic [hrwp_pkg::COUNT_W-1:0]  cfg_data_i   = '0;

  txn_t        stim_q[$];
  pixel_t      pixel_q[$];
  logic        in_fire      = 1'b0;
  logic        cfg_fire     = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned errors       = 0;
  int unsigned n_queued     = 0;
  int unsigned n_bases      = 0;
  int unsigned n_pixels     = 0;
  int unsigned n_cfg        = 0;
  int unsigned in_gap       = 0;
  int unsigned out_gap      = 0;
  int unsigned quiet        = 0;
  bit          idle_on      = 1'b1;

  // predictor state
  logic [hrwp_pkg::COUNT_W-1:0] weight_cfg = hrwp_pkg::MAX_WEIGHT_RESET;
  logic [hrwp_pkg::BASE_W-1:0]  run_base   = '0;
  logic [hrwp_pkg::COUNT_W-1:0] run_held   = '0;
  logic                         run_open   = 1'b0;
  logic                         run_full   = 1'b0;

  homopolymer_run_weight_pixels_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .base_i       (base_i),
    .last_i       (last_i),
    .empty        (empty),
    .pop          (pop),
    .pixel_o      (pixel_o),
    .last_pixel_o (last_pixel_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned sat_len(input logic [hrwp_pkg::COUNT_W-1:0] w);
    int unsigned m;
    m = (w == '0) ? 1 : int'(w);
    if (m > hrwp_pkg::MAX_WEIGHT_LIMIT) m = hrwp_pkg::MAX_WEIGHT_LIMIT;
    return m;
  endfunction

  task automatic emit_pixels(input int unsigned value, input int unsigned count);
    pixel_t px;
    px.pixel = value[hrwp_pkg::PIXEL_W-1:0];
    px.last  = 1'b0;
    repeat (count) pixel_q.push_back(px);
  endtask

  task automatic flush_run(input int unsigned m);
    int unsigned w;
    w = run_held;
    if (w > 0) begin
      if (w > m) w = m;
      emit_pixels((int'(hrwp_pkg::PIXEL_FULL) * w) / m, run_held);
    end
    run_held = '0;
  endtask

  task automatic predict_pixels(input logic [hrwp_pkg::BASE_W-1:0] b, input logic lst);
    int unsigned m;
    int unsigned before_n;
    m        = sat_len(weight_cfg);
    before_n = pixel_q.size();
    if (run_open && b == run_base) begin
      if (run_full) begin
        emit_pixels(hrwp_pkg::PIXEL_FULL, 1);
      end else if (int'(run_held) + 1 >= m) begin
        emit_pixels(hrwp_pkg::PIXEL_FULL, int'(run_held) + 1);
        run_held = '0;
        run_full = 1'b1;
      end else begin
        run_held = run_held + 1'b1;
      end
    end else begin
      if (run_open && !run_full) flush_run(m);
      run_held = '0;
      run_base = b;
      run_open = 1'b1;
      if (m <= 1) begin
        emit_pixels(hrwp_pkg::PIXEL_FULL, 1);
        run_full = 1'b1;
      end else begin
        run_held = hrwp_pkg::COUNT_W'(1);
        run_full = 1'b0;
      end
    end
    if (lst) begin
      if (!run_full) flush_run(m);
      if (pixel_q.size() > before_n) pixel_q[pixel_q.size()-1].last = 1'b1;
      run_base = '0;
      run_held = '0;
      run_open = 1'b0;
      run_full = 1'b0;
    end
  endtask

  task automatic add_base(input logic [hrwp_pkg::BASE_W-1:0] b, input logic lst);
    txn_t t;
    t.kind = TXN_BASE;
    t.base = b;
    t.last = lst;
    t.data = '0;
    stim_q.push_back(t);
    n_queued++;
  endtask

  task automatic add_ctl(input txn_kind_e kind, input logic [hrwp_pkg::COUNT_W-1:0] value);
    txn_t t;
    t.kind = kind;
    t.base = '0;
    t.last = 1'b0;
    t.data = value;
    stim_q.push_back(t);
  endtask

  task automatic add_run(input logic [hrwp_pkg::BASE_W-1:0] b, input int unsigned n,
                         input logic lst);
    for (int unsigned k = 0; k < n; k++) add_base(b, lst && (k == n - 1));
  endtask

  task automatic add_sequence(input int unsigned m, input int unsigned len, input bit close);
    logic [hrwp_pkg::BASE_W-1:0] alpha [3];
    int unsigned                 left;
    int unsigned                 run;
    for (int i = 0; i < 3; i++) alpha[i] = $urandom_range(0, 255);
    left = len;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0:       run = $urandom_range(1, 2);
        1:       run = $urandom_range((m > 1) ? m - 1 : 1, m + 1);
        2:       run = $urandom_range(1, m + 3);
        default: run = $urandom_range(1, 4);
      endcase
      if (run > left) run = left;
      add_run(alpha[$urandom_range(0, 2)], run, close && (run == left));
      left -= run;
    end
  endtask

  // monitor: sample on the rising edge
  always @(posedge clk_i) begin : monitor
    pixel_t want;
    if (!rst_ni) begin
      in_fire      <= 1'b0;
      cfg_fire     <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_fire  <= push && !full;
      cfg_fire <= cfg_valid_i && cfg_ready_o;
      if (pop && !empty) begin
        n_pixels++;
        if (pixel_q.size() == 0) begin
          $error("pixel %0d popped with no expectation waiting", pixel_o);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (pixel_o !== want.pixel) begin
            $error("pixel: expected %0d, actual %0d", want.pixel, pixel_o);
            errors++;
          end
          if (last_pixel_o !== want.last) begin
            $error("last_pixel: expected %0d, actual %0d", want.last, last_pixel_o);
            errors++;
          end
        end
      end
      if (push && !full) begin
        predict_pixels(base_i, last_i);
        n_bases++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        weight_cfg = cfg_data_i;
        n_cfg++;
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // driver: change inputs on the falling edge
  always @(negedge clk_i) begin : driver
    logic nxt_push;
    logic nxt_cfg;
    logic nxt_pop;
    bit   calm;
    nxt_push = 1'b0;
    nxt_cfg  = 1'b0;
    nxt_pop  = 1'b0;
    if (rst_ni) begin
      if (in_fire || cfg_fire) stim_q.delete(0);
      if ($urandom_range(0, 63) == 0) idle_on = $urandom_range(0, 1);
      calm = (stim_q.size() < TAIL_TXNS) || !idle_on;
      if (push && !in_fire) begin
        nxt_push = 1'b1;
      end else if (cfg_valid_i && !cfg_fire) begin
        nxt_cfg = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
      end else if (stim_q.size() > 0) begin
        case (stim_q[0].kind)
          TXN_BASE: begin
            if (!calm && $urandom_range(0, 5) == 0) begin
              in_gap = $urandom_range(0, 2);
            end else begin
              nxt_push = 1'b1;
              base_i   <= stim_q[0].base;
              last_i   <= stim_q[0].last;
            end
          end
          TXN_CFG: begin
            if (quiet >= QUIET_CYCLES) begin
              nxt_cfg    = 1'b1;
              cfg_data_i <= stim_q[0].data;
            end
          end
          default: begin
            if (quiet >= QUIET_CYCLES) stim_q.delete(0);
          end
        endcase
      end
      if (out_gap > 0) begin
        out_gap--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 2);
      end else begin
        nxt_pop = 1'b1;
      end
      if (pixel_q.size() == 0 && !nxt_push) quiet++;
      else quiet = 0;
    end
    push        <= nxt_push;
    cfg_valid_i <= nxt_cfg;
    pop         <= nxt_pop;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [hrwp_pkg::COUNT_W-1:0] weights [8];
    int unsigned                  m;
    int unsigned                  phase_start;

    // directed: single base, saturation, mid-run writes, zero max_weight
    add_run(8'h00, 1, 1'b1);
    add_run(8'hFF, 7, 1'b0);
    add_run(8'h00, 1, 1'b1);
    add_run(8'hA5, 2, 1'b0);
    add_run(8'h5A, 1, 1'b1);
    add_run(8'h33, 4, 1'b0);
    add_ctl(TXN_CFG, hrwp_pkg::COUNT_W'(2));
    add_run(8'h33, 1, 1'b0);
    add_run(8'h34, 1, 1'b1);
    add_ctl(TXN_CFG, hrwp_pkg::COUNT_W'(6));
    add_run(8'h77, 5, 1'b0);
    add_ctl(TXN_CFG, hrwp_pkg::COUNT_W'(3));
    add_run(8'h78, 1, 1'b1);
    add_ctl(TXN_CFG, hrwp_pkg::COUNT_W'(0));
    add_run(8'h41, 2, 1'b0);
    add_run(8'h42, 1, 1'b1);

    weights[0] = hrwp_pkg::COUNT_W'(hrwp_pkg::MAX_WEIGHT_LIMIT);
    weights[1] = hrwp_pkg::COUNT_W'(1);
    weights[2] = hrwp_pkg::COUNT_W'(0);
    weights[3] = hrwp_pkg::COUNT_W'(2);
    weights[4] = hrwp_pkg::COUNT_W'($urandom_range(3, 62));
    weights[5] = hrwp_pkg::COUNT_W'(40);
    weights[6] = hrwp_pkg::COUNT_W'(5);
    weights[7] = hrwp_pkg::MAX_WEIGHT_RESET;

    foreach (weights[p]) begin
      add_ctl(TXN_CFG, weights[p]);
      m = sat_len(weights[p]);
      if (m == hrwp_pkg::MAX_WEIGHT_LIMIT) add_run($urandom_range(0, 255), LONG_RUN, 1'b1);
      phase_start = n_queued;
      while (n_queued - phase_start < PHASE_BASES) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 5))
               add_base($urandom_range(0, 255), $urandom_range(0, 3) == 0);
          1: add_ctl(TXN_DRAIN, '0);
          default: add_sequence(m, $urandom_range(1, 20), 1'b1);
        endcase
      end
      // hold a run open across the next write
      if ($urandom_range(0, 1) == 1) add_sequence(m, $urandom_range(1, 6), 1'b0);
    end
    add_run($urandom_range(0, 255), 1, 1'b1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || pixel_q.size() != 0 || push) @(posedge clk_i);
    repeat (48) @(posedge clk_i);

    $display("Covered %0d bases and %0d pixels over %0d max_weight writes,",
             n_bases, n_pixels, n_cfg);
    $display("including zero and full saturation lengths and writes inside open runs.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
